// ===== rtl/core/crv_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the CORDIC core.
// No dependencies; every module of the core imports this package.
package crv_pkg;

    // pi/4 in unsigned Q2.62; pi, pi/2 and the first arctangent entry derive from it.
    localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;

    // Gain-removal shift-add sequence, applied after the micro-rotations.
    localparam int SCALE_STEPS = 7;
    localparam int SCALE_SHIFT [SCALE_STEPS] = '{1, 2, 5, 10, 16, 19, 22};

    // How the input vector was folded before the micro-rotations.
    typedef enum logic [1:0] {
        QUAD_NONE,      // no folding
        QUAD_FOLD,      // rotation angle folded by pi, result is negated
        QUAD_LEFT_POS,  // vectoring, left half plane with y above zero
        QUAD_LEFT_NEG   // vectoring, left half plane with y at or below zero
    } quad_t;

    // Control word that travels with each beat down the pipeline.
    typedef struct packed {
        logic  vec;     // vectoring mode
        quad_t quad;
    } crv_ctl_t;

    // Floor of 2^e / d by restoring long division, used at elaboration only.
    function automatic logic [63:0] pow2_div(input int e, input int d);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] dd;
        q  = '0;
        r  = '0;
        dd = 64'(d);
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], (b == e)};
            if (r >= dd) begin
                r    = r - dd;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Floor of atan(2^-i) scaled by 2^frac, from the truncated series for i 1 to 10.
    function automatic logic [63:0] atan_entry(input int i, input int frac);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum  = '0;
        term = '0;
        if (i == 0) begin
            return PI4_Q62 >> (62 - frac);
        end
        if (i <= 10) begin
            for (int k = 0; k < 32; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = pow2_div(e, 2 * k + 1);
                    sum  = ((k & 1) == 1) ? sum - term : sum + term;
                end
            end
            return sum >> (62 - frac);
        end
        if (i <= frac) begin
            return (64'd1 << (frac - i)) - 64'd1;
        end
        return '0;
    endfunction

endpackage

// ===== rtl/core/cordic_rotate_vector_core.sv =====
// CORDIC rotation / vectoring core, signed fixed point (Q3.13 by default).
// A beat passes the pre-rotation register, the micro-rotation and gain-step registers, then the output register.
// Throughput: one beat per cycle while the skid register is empty; each micro-rotation and each gain step owns a stage.
// Reset: synchronous, active low on aresetn; it clears all valid bits, payload is not reset.
// Depends on crv_pkg, crv_prerot, crv_microrot, crv_scale and crv_outbuf.
module cordic_rotate_vector_core import crv_pkg::*; #(
    parameter int ITERATIONS = 16,
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 13
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic signed [DATA_WIDTH-1:0] s_x_value,
    input  logic signed [DATA_WIDTH-1:0] s_y_value,
    input  logic signed [DATA_WIDTH-1:0] s_angle_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_x_result,
    output logic signed [DATA_WIDTH-1:0] m_y_result,
    output logic signed [DATA_WIDTH-1:0] m_angle_result
);

    // The vector datapath carries four guard bits above the word: one for the
    // left-half-plane swap, the rest for the CORDIC gain of about 1.65 on a
    // full-scale diagonal vector. The angle path is wide enough for the folded
    // target, the accumulated arctangent sum and the pi/2 offset, whatever the
    // split between word width and fraction bits.
    localparam int XW = DATA_WIDTH + 4;
    localparam int AW = ((DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3) + 2;

    // Stage 0 is the pre-rotation, then one stage per micro-rotation and one
    // per gain-removal step.
    localparam int NS = ITERATIONS + SCALE_STEPS + 1;

    logic                 valid_pipe [NS];
    crv_ctl_t             ctl_pipe   [NS];
    logic signed [XW-1:0] x_pipe     [NS];
    logic signed [XW-1:0] y_pipe     [NS];
    logic signed [AW-1:0] z_pipe     [NS];

    logic adv;
    logic skid_full;

    // The whole pipeline moves together. It stops only when the output
    // register holds an unaccepted beat and the skid register has caught
    // the next one, so a stall on the result side never drops or repeats a
    // beat, and the input side keeps taking beats while one result waits.
    // The stall comes from a register, so no path runs from m_ready to s_ready.
    assign adv     = !skid_full;
    assign s_ready = adv;

    crv_prerot #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .XW         (XW),
        .AW         (AW)
    ) u_prerot (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (s_valid),
        .op          (s_op),
        .x_value     (s_x_value),
        .y_value     (s_y_value),
        .angle_value (s_angle_value),
        .out_valid   (valid_pipe[0]),
        .out_ctl     (ctl_pipe[0]),
        .out_x       (x_pipe[0]),
        .out_y       (y_pipe[0]),
        .out_z       (z_pipe[0])
    );

    // Micro-rotations: stage i shifts by i and uses the i-th arctangent entry.
    // The residual angle z counts down toward zero in rotation mode and ends
    // as the negated accumulated angle in vectoring mode.
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
        crv_microrot #(
            .FRAC_BITS (FRAC_BITS),
            .XW        (XW),
            .AW        (AW),
            .IDX       (i)
        ) u_rot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (valid_pipe[i]),
            .in_ctl    (ctl_pipe[i]),
            .in_x      (x_pipe[i]),
            .in_y      (y_pipe[i]),
            .in_z      (z_pipe[i]),
            .out_valid (valid_pipe[i+1]),
            .out_ctl   (ctl_pipe[i+1]),
            .out_x     (x_pipe[i+1]),
            .out_y     (y_pipe[i+1]),
            .out_z     (z_pipe[i+1])
        );
    end

    // Gain removal: the first and third steps subtract (for y only in rotation mode), the others add.
    for (genvar j = 0; j < SCALE_STEPS; j++) begin : g_scale
        crv_scale #(
            .XW    (XW),
            .AW    (AW),
            .SHIFT (SCALE_SHIFT[j]),
            .SUB   ((j == 0) || (j == 2))
        ) u_scale (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (valid_pipe[ITERATIONS+j]),
            .in_ctl    (ctl_pipe[ITERATIONS+j]),
            .in_x      (x_pipe[ITERATIONS+j]),
            .in_y      (y_pipe[ITERATIONS+j]),
            .in_z      (z_pipe[ITERATIONS+j]),
            .out_valid (valid_pipe[ITERATIONS+j+1]),
            .out_ctl   (ctl_pipe[ITERATIONS+j+1]),
            .out_x     (x_pipe[ITERATIONS+j+1]),
            .out_y     (y_pipe[ITERATIONS+j+1]),
            .out_z     (z_pipe[ITERATIONS+j+1])
        );
    end

    crv_outbuf #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .XW         (XW),
        .AW         (AW)
    ) u_outbuf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (valid_pipe[NS-1]),
        .in_ctl         (ctl_pipe[NS-1]),
        .in_x           (x_pipe[NS-1]),
        .in_y           (y_pipe[NS-1]),
        .in_z           (z_pipe[NS-1]),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_x_result     (m_x_result),
        .m_y_result     (m_y_result),
        .m_angle_result (m_angle_result),
        .skid_full      (skid_full)
    );

`ifndef SYNTHESIS
    // The skid register only fills behind a result that is already shown.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full |-> m_valid)
        else $error("skid register holds a beat while the output is empty");

    // A caught beat stays in the skid register until the output is taken.
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full && !m_ready) |=> skid_full)
        else $error("skid beat lost during an output stall");

    // Each mode zeroes one result field: y in vectoring, the angle in rotation.
    a_mode_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_y_result == '0 || m_angle_result == '0))
        else $error("both y and angle results are nonzero");
`endif

endmodule

// ===== rtl/core/crv_prerot.sv =====
// Input stage of the CORDIC core: angle folding and left-half-plane pre-rotation.
// Depends on crv_pkg for the control word and the pi constant.
module crv_prerot import crv_pkg::*; #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 13,
    parameter int XW         = 20,
    parameter int AW         = 18
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic                         op,
    input  logic signed [DATA_WIDTH-1:0] x_value,
    input  logic signed [DATA_WIDTH-1:0] y_value,
    input  logic signed [DATA_WIDTH-1:0] angle_value,
    output logic                         out_valid,
    output crv_ctl_t                     out_ctl,
    output logic signed [XW-1:0]         out_x,
    output logic signed [XW-1:0]         out_y,
    output logic signed [AW-1:0]         out_z
);

    localparam logic signed [AW-1:0] PI_F    = AW'(PI4_Q62 >> (60 - FRAC_BITS));
    localparam logic signed [AW-1:0] HALF_PI = AW'(PI4_Q62 >> (61 - FRAC_BITS));

    logic                  valid_reg;
    crv_ctl_t              ctl_reg, ctl_next;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  y_reg, y_next;
    logic signed [AW-1:0]  z_reg, z_next;
    logic signed [XW-1:0]  x_ext, y_ext;
    logic signed [AW-1:0]  ang_ext;

    always_comb begin
        x_ext         = XW'(x_value);
        y_ext         = XW'(y_value);
        ang_ext       = AW'(angle_value);
        ctl_next.vec  = op;
        ctl_next.quad = QUAD_NONE;
        x_next        = x_ext;
        y_next        = y_ext;
        z_next        = '0;
        if (!op) begin
            // The residual angle starts at the folded target.
            if (ang_ext < -HALF_PI) begin
                z_next        = ang_ext + PI_F;
                ctl_next.quad = QUAD_FOLD;
            end else if (ang_ext > HALF_PI) begin
                z_next        = ang_ext - PI_F;
                ctl_next.quad = QUAD_FOLD;
            end else begin
                z_next = ang_ext;
            end
        end else if (x_ext[XW-1]) begin
            if (y_ext > 0) begin
                x_next        = y_ext;
                y_next        = -x_ext;
                ctl_next.quad = QUAD_LEFT_POS;
            end else begin
                x_next        = -y_ext;
                y_next        = x_ext;
                ctl_next.quad = QUAD_LEFT_NEG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg <= ctl_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ===== rtl/core/crv_microrot.sv =====
// One registered CORDIC micro-rotation with a fixed shift and arctangent step.
// Depends on crv_pkg for the control word and the arctangent table function.
module crv_microrot import crv_pkg::*; #(
    parameter int FRAC_BITS = 13,
    parameter int XW        = 20,
    parameter int AW        = 18,
    parameter int IDX       = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  crv_ctl_t             in_ctl,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  logic signed [AW-1:0] in_z,
    output logic                 out_valid,
    output crv_ctl_t             out_ctl,
    output logic signed [XW-1:0] out_x,
    output logic signed [XW-1:0] out_y,
    output logic signed [AW-1:0] out_z
);

    localparam logic signed [AW-1:0] ATAN_STEP = AW'(atan_entry(IDX, FRAC_BITS));

    logic                  valid_reg;
    crv_ctl_t              ctl_reg;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  y_reg, y_next;
    logic signed [AW-1:0]  z_reg, z_next;
    logic signed [XW-1:0]  dx, dy;
    logic                  up;

    always_comb begin
        dx = in_y >>> IDX;
        dy = in_x >>> IDX;
        // Rotation chases a positive residual angle; vectoring drives y to zero.
        up = in_ctl.vec ? in_y[XW-1]
                        : (!in_z[AW-1] && (in_z != '0));
        if (up) begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN_STEP;
        end else begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg <= in_ctl;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ===== rtl/core/crv_scale.sv =====
// One registered step of the shift-add gain removal.
// Depends on crv_pkg for the control word.
module crv_scale import crv_pkg::*; #(
    parameter int XW    = 20,
    parameter int AW    = 18,
    parameter int SHIFT = 1,
    parameter bit SUB   = 1'b0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  crv_ctl_t             in_ctl,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  logic signed [AW-1:0] in_z,
    output logic                 out_valid,
    output crv_ctl_t             out_ctl,
    output logic signed [XW-1:0] out_x,
    output logic signed [XW-1:0] out_y,
    output logic signed [AW-1:0] out_z
);

    logic                  valid_reg;
    crv_ctl_t              ctl_reg;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  y_reg, y_next;
    logic signed [AW-1:0]  z_reg;
    logic signed [XW-1:0]  dx, dy;

    always_comb begin
        dx     = in_x >>> SHIFT;
        dy     = in_y >>> SHIFT;
        x_next = SUB ? in_x - dx : in_x + dx;
        // In vectoring mode y always adds; it is not part of that result.
        y_next = (SUB && !in_ctl.vec) ? in_y - dy : in_y + dy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg <= in_ctl;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= in_z;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ===== rtl/core/crv_outbuf.sv =====
// Result stage: sign fix-up, angle offset, saturation, output register and skid register.
// Depends on crv_pkg for the control word and the pi constant.
module crv_outbuf import crv_pkg::*; #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 13,
    parameter int XW         = 20,
    parameter int AW         = 18
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  crv_ctl_t                     in_ctl,
    input  logic signed [XW-1:0]         in_x,
    input  logic signed [XW-1:0]         in_y,
    input  logic signed [AW-1:0]         in_z,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic signed [DATA_WIDTH-1:0] m_x_result,
    output logic signed [DATA_WIDTH-1:0] m_y_result,
    output logic signed [DATA_WIDTH-1:0] m_angle_result,
    output logic                         skid_full
);

    localparam logic signed [AW-1:0] HALF_PI = AW'(PI4_Q62 >> (61 - FRAC_BITS));
    localparam logic signed [XW-1:0] X_MAX   = XW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic signed [XW-1:0] X_MIN   = -X_MAX - XW'(1);
    localparam logic signed [AW-1:0] A_MAX   = AW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic signed [AW-1:0] A_MIN   = -A_MAX - AW'(1);

    logic signed [XW-1:0]         xf, yf;
    logic signed [AW-1:0]         af;
    logic signed [DATA_WIDTH-1:0] xs, ys, as_val;
    logic signed [DATA_WIDTH-1:0] x_res, y_res, a_res;

    logic                         m_valid_reg, m_valid_next;
    logic                         skid_valid_reg, skid_valid_next;
    logic signed [DATA_WIDTH-1:0] x_out_reg, y_out_reg, a_out_reg;
    logic signed [DATA_WIDTH-1:0] x_skid_reg, y_skid_reg, a_skid_reg;
    logic                         load_out, load_skid, from_skid;

    // Final corrections and saturation to the output word.
    always_comb begin
        if (!in_ctl.vec && in_ctl.quad == QUAD_FOLD) begin
            xf = -in_x;
            yf = -in_y;
        end else begin
            xf = in_x;
            yf = in_y;
        end
        case (in_ctl.quad)
            QUAD_LEFT_POS: af = in_z + HALF_PI;
            QUAD_LEFT_NEG: af = in_z - HALF_PI;
            default:       af = in_z;
        endcase
        xs     = (xf > X_MAX) ? DATA_WIDTH'(X_MAX) :
                 (xf < X_MIN) ? DATA_WIDTH'(X_MIN) : DATA_WIDTH'(xf);
        ys     = (yf > X_MAX) ? DATA_WIDTH'(X_MAX) :
                 (yf < X_MIN) ? DATA_WIDTH'(X_MIN) : DATA_WIDTH'(yf);
        as_val = (af > A_MAX) ? DATA_WIDTH'(A_MAX) :
                 (af < A_MIN) ? DATA_WIDTH'(A_MIN) : DATA_WIDTH'(af);
        x_res  = xs;
        y_res  = in_ctl.vec ? '0 : ys;
        a_res  = in_ctl.vec ? as_val : '0;
    end

    // The pipeline hands over a beat only while the skid register is empty.
    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        from_skid       = 1'b0;
        if (skid_valid_reg) begin
            if (m_ready) begin
                from_skid       = 1'b1;
                load_out        = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!m_valid_reg || m_ready) begin
                load_out     = 1'b1;
                m_valid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            x_out_reg <= from_skid ? x_skid_reg : x_res;
            y_out_reg <= from_skid ? y_skid_reg : y_res;
            a_out_reg <= from_skid ? a_skid_reg : a_res;
        end
        if (load_skid) begin
            x_skid_reg <= x_res;
            y_skid_reg <= y_res;
            a_skid_reg <= a_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_x_result     = x_out_reg;
    assign m_y_result     = y_out_reg;
    assign m_angle_result = a_out_reg;
    assign skid_full      = skid_valid_reg;

endmodule

// ===== bench/tb_cordic_rotate_vector_core.sv =====
// Self-checking bench for cordic_rotate_vector_core: rotation and vectoring beats are
// checked field by field against a bit-exact CORDIC model kept in this file.
// Depends on crv_pkg (quad_t) and the core at its default parameters.
`timescale 1ns / 100ps

module tb_cordic_rotate_vector_core;
    import crv_pkg::*;

    // Word layout of the core at its default parameters (signed Q3.13).
    localparam int DW         = 16;
    localparam int FRAC       = 13;
    localparam int ITERS      = 16;
    localparam int GAIN_STEPS = 7;

    // Operation codes carried on s_op.
    localparam logic OP_ROTATE = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    // pi and pi/2 truncated toward minus infinity to 13 fraction bits.
    localparam longint PI_Q13      = 25735;
    localparam longint HALF_PI_Q13 = 12867;

    // Largest angle magnitude that the angle port is driven with; just beyond pi.
    localparam int ANGLE_SPAN = 25736;

    // After the last result the bench keeps watching the output for any stray beat.
    localparam int DRAIN_CYCLES = 80;

    // Long receiver hold-off used to fill the pipeline and stall the input.
    localparam int HOLD_CYCLES = 400;

    // Fixed time budget for the whole run.
    localparam realtime RUN_LIMIT = 2ms;

    typedef struct {
        logic                 op;
        logic signed [DW-1:0] x_in;
        logic signed [DW-1:0] y_in;
        logic signed [DW-1:0] angle_in;
        logic signed [DW-1:0] x_result;
        logic signed [DW-1:0] y_result;
        logic signed [DW-1:0] angle_result;
    } cordic_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_op = OP_ROTATE;
    logic signed [DW-1:0] s_x_value = '0;
    logic signed [DW-1:0] s_y_value = '0;
    logic signed [DW-1:0] s_angle_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [DW-1:0] m_x_result;
    logic signed [DW-1:0] m_y_result;
    logic signed [DW-1:0] m_angle_result;

    // floor(atan(2^-i) * 2^13), filled at the start of the run.
    longint atan_q13 [ITERS];
    // Gain-removal shifts; steps 0 and 2 subtract, the rest add.
    int     gain_shift [GAIN_STEPS] = '{1, 2, 5, 10, 16, 19, 22};

    // Model outputs for beats that the core has accepted but not yet returned.
    cordic_beat_t pending_cordic [$];

    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    logic sink_hold = 1'b0;

    int  error_count = 0;
    int  checked_count = 0;
    int  rotate_count = 0;
    int  vector_count = 0;

    cordic_rotate_vector_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_x_value      (s_x_value),
        .s_y_value      (s_y_value),
        .s_angle_value  (s_angle_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_x_result     (m_x_result),
        .m_y_result     (m_y_result),
        .m_angle_result (m_angle_result)
    );

    // 4 ns clock: two ns low, two ns high.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Clamp a wide intermediate value to the signed 16-bit output range.
    function automatic logic signed [DW-1:0] clamp_q13(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return DW'(v);
    endfunction

    // Bit-exact CORDIC. All arithmetic is done in 64-bit integers, so nothing
    // wraps before the final saturation, and >>> rounds toward minus infinity.
    function automatic cordic_beat_t compute_cordic(input logic op,
                                                    input logic signed [DW-1:0] xv,
                                                    input logic signed [DW-1:0] yv,
                                                    input logic signed [DW-1:0] av);
        cordic_beat_t r;
        longint       x;
        longint       y;
        longint       t;
        longint       target;
        longint       theta;
        longint       dx;
        longint       dy;
        longint       a;
        quad_t        quad;
        logic         vec;
        logic         up;
        logic         sub;
        r.op       = op;
        r.x_in     = xv;
        r.y_in     = yv;
        r.angle_in = av;
        vec    = (op == OP_VECTOR);
        x      = xv;
        y      = yv;
        target = 0;
        theta  = 0;
        quad   = QUAD_NONE;

        // Rotation folds the angle into [-pi/2, pi/2] once and negates at the end.
        // Vectoring turns a left-half-plane vector by a quarter turn first.
        if (!vec) begin
            if (av < -HALF_PI_Q13) begin
                target = av + PI_Q13;
                quad   = QUAD_FOLD;
            end else if (av > HALF_PI_Q13) begin
                target = av - PI_Q13;
                quad   = QUAD_FOLD;
            end else begin
                target = av;
            end
        end else if (x < 0) begin
            t = x;
            if (y > 0) begin
                x    = y;
                y    = -t;
                quad = QUAD_LEFT_POS;
            end else begin
                x    = -y;
                y    = t;
                quad = QUAD_LEFT_NEG;
            end
        end

        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            up = vec ? (y < 0) : (theta < target);
            if (up) begin
                x     = x - dx;
                y     = y + dy;
                theta = theta + atan_q13[i];
            end else begin
                x     = x + dx;
                y     = y - dy;
                theta = theta - atan_q13[i];
            end
        end

        // In vectoring mode y always takes the add path; it is not output anyway.
        for (int j = 0; j < GAIN_STEPS; j++) begin
            dx  = x >>> gain_shift[j];
            dy  = y >>> gain_shift[j];
            sub = (j == 0 || j == 2);
            x   = sub ? x - dx : x + dx;
            y   = (sub && !vec) ? y - dy : y + dy;
        end

        if (!vec) begin
            if (quad == QUAD_FOLD) begin
                x = -x;
                y = -y;
            end
            r.x_result     = clamp_q13(x);
            r.y_result     = clamp_q13(y);
            r.angle_result = '0;
        end else begin
            a = -theta;
            if (quad == QUAD_LEFT_POS) begin
                a = a + HALF_PI_Q13;
            end
            if (quad == QUAD_LEFT_NEG) begin
                a = a - HALF_PI_Q13;
            end
            r.x_result     = clamp_q13(x);
            r.y_result     = '0;
            r.angle_result = clamp_q13(a);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Offers one beat, holds it until the core takes it, then records the model
    // output. Valid is only lowered when a gap is rolled, so it never drops and
    // rises again in the same time step.
    task automatic send_beat(input logic op, input logic signed [DW-1:0] xv,
                             input logic signed [DW-1:0] yv,
                             input logic signed [DW-1:0] av);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < src_idle_pct);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_x_value     <= xv;
        s_y_value     <= yv;
        s_angle_value <= av;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_cordic.push_back(compute_cordic(op, xv, yv, av));
        if (op == OP_VECTOR) begin
            vector_count++;
        end else begin
            rotate_count++;
        end
    endtask

    // Vector components: a third full range (saturation and the extremes),
    // the rest within the unit square, where the results stay in range.
    function automatic logic signed [DW-1:0] random_component();
        case ($urandom_range(2))
            0: begin
                return DW'($urandom);
            end
            1: begin
                return DW'(int'($urandom_range(16384)) - 8192);
            end
            default: begin
                return DW'(int'($urandom_range(4096)) - 2048);
            end
        endcase
    endfunction

    task automatic send_random_beat();
        logic                 op;
        logic signed [DW-1:0] av;
        op = 1'($urandom_range(1));
        av = DW'(int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN);
        send_beat(op, random_component(), random_component(), av);
    endtask

    // Angles at zero, at and just past +-pi/2 (the fold boundary), at +-pi and
    // just beyond it, with unit, saturating, most-negative and zero vectors.
    task automatic test_directed_rotation();
        send_beat(OP_ROTATE, 16'sd8192, 16'sd0, 16'sd0);
        send_beat(OP_ROTATE, 16'sd8192, 16'sd0, 16'sd12867);
        send_beat(OP_ROTATE, 16'sd8192, 16'sd0, 16'sd12868);
        send_beat(OP_ROTATE, 16'sd8192, 16'sd0, -16'sd12867);
        send_beat(OP_ROTATE, 16'sd8192, 16'sd0, -16'sd12868);
        send_beat(OP_ROTATE, 16'sd8192, 16'sd0, 16'sd25735);
        send_beat(OP_ROTATE, 16'sd8192, 16'sd0, -16'sd25735);
        send_beat(OP_ROTATE, 16'sd8192, 16'sd4096, 16'sd25736);
        send_beat(OP_ROTATE, 16'sd8192, 16'sd4096, -16'sd25736);
        send_beat(OP_ROTATE, 16'sd32767, 16'sd32767, 16'sd6434);
        send_beat(OP_ROTATE, -16'sd32768, -16'sd32768, -16'sd20000);
        send_beat(OP_ROTATE, 16'sd0, 16'sd0, 16'sd1000);
    endtask

    // Both left-half-plane cases (y above zero, y at or below zero), the axes,
    // the zero vector and corner vectors whose magnitude saturates.
    task automatic test_directed_vectoring();
        send_beat(OP_VECTOR, 16'sd8192, 16'sd0, 16'sd0);
        send_beat(OP_VECTOR, 16'sd0, 16'sd8192, 16'sd0);
        send_beat(OP_VECTOR, -16'sd8192, 16'sd4096, 16'sd0);
        send_beat(OP_VECTOR, -16'sd8192, 16'sd0, 16'sd0);
        send_beat(OP_VECTOR, -16'sd8192, -16'sd4096, 16'sd0);
        send_beat(OP_VECTOR, 16'sd0, 16'sd0, 16'sd25736);
        send_beat(OP_VECTOR, -16'sd32768, -16'sd32768, -16'sd25736);
        send_beat(OP_VECTOR, 16'sd32767, 16'sd32767, 16'sd0);
        send_beat(OP_VECTOR, -16'sd32768, 16'sd32767, 16'sd0);
        send_beat(OP_VECTOR, 16'sd32767, -16'sd32768, 16'sd0);
        send_beat(OP_VECTOR, 16'sd0, -16'sd32768, 16'sd0);
    endtask

    // A run of random beats under one idling profile on each side.
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        src_idle_pct = idle_pct;
        sink_stall_pct <= stall_pct;
        repeat (count) begin
            send_random_beat();
        end
    endtask

    // The receiver refuses beats for a long stretch while the sender keeps
    // offering back to back, so the pipeline fills and s_ready has to drop.
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold <= 1'b0;
            end
        join_none
        repeat (120) begin
            send_random_beat();
        end
    endtask

    // Result side: every accepted beat is checked against the oldest pending
    // model output, then m_ready for the next edge is chosen.
    always @(posedge aclk) begin
        cordic_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cordic.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending x=%0d y=%0d a=%0d",
                                          m_x_result, m_y_result, m_angle_result));
            end else begin
                want = pending_cordic.pop_front();
                checked_count++;
                if (m_x_result !== want.x_result) begin
                    report_mismatch($sformatf("op=%0d in=(%0d,%0d,%0d) x_result %0d, want %0d",
                                              want.op, want.x_in, want.y_in, want.angle_in,
                                              m_x_result, want.x_result));
                end
                if (m_y_result !== want.y_result) begin
                    report_mismatch($sformatf("op=%0d in=(%0d,%0d,%0d) y_result %0d, want %0d",
                                              want.op, want.x_in, want.y_in, want.angle_in,
                                              m_y_result, want.y_result));
                end
                if (m_angle_result !== want.angle_result) begin
                    report_mismatch($sformatf("op=%0d in=(%0d,%0d,%0d) angle_result %0d, want %0d",
                                              want.op, want.x_in, want.y_in, want.angle_in,
                                              m_angle_result, want.angle_result));
                end
            end
        end
        if (sink_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Hard stop in case the core hangs or loses beats.
    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        real step;
        // Arctangent table, floored to 13 fraction bits.
        step = 1.0;
        for (int i = 0; i < ITERS; i++) begin
            atan_q13[i] = longint'($floor($atan(step) * real'(1 << FRAC)));
            step = step / 2.0;
        end

        // Reset is held at the start of the run and released once.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_rotation();
        test_directed_vectoring();
        test_random(340, 0, 0);
        test_random(340, 48, 0);
        test_random(340, 0, 48);
        test_random(340, 14, 14);
        test_backpressure();

        s_valid <= 1'b0;
        while (pending_cordic.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d rotation and %0d vectoring beats; %0d results compared.",
                 rotate_count, vector_count, checked_count);
        $display("Profiles: free flow, idle sender, stalling receiver, both, long hold-off.");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
